// File: hw/rtl/svsq_pkg.sv
// ----------------------------------------------------------------------------
// Servo sweep sequencer package
// Word types, field widths, command and phase codes, register indexes and
// reset values shared by the sweep sequencer RTL.
// ----------------------------------------------------------------------------
package svsq_pkg;

   localparam int SERVO_COUNT_DEF = 4;

   localparam int CHAN_W     = 2;
   localparam int ANGLE_W    = 8;
   localparam int TIME_W     = 32;
   localparam int MS_W       = 16;
   localparam int PULSE_W    = 12;
   localparam int MASK_W     = 4;
   localparam int TIMING_W   = 48;
   localparam int PROFILE_W  = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 48;
   localparam int NUM_TIMING = 4;

   // serial divider: quotient never exceeds the pulse span, so 12 steps do
   localparam int DIV_STEPS  = 12;
   localparam int DIV_CNT_W  = 4;
   localparam int PRODUCT_W  = PULSE_W + ANGLE_W;

   typedef logic [1:0] kind_type;
   localparam kind_type KIND_TICK    = 2'd0;
   localparam kind_type KIND_TRIGGER = 2'd1;
   localparam kind_type KIND_SET     = 2'd2;
   localparam kind_type KIND_STOP    = 2'd3;

   typedef logic [1:0] phase_type;
   localparam phase_type PH_IDLE      = 2'd0;
   localparam phase_type PH_AT_END    = 2'd1;
   localparam phase_type PH_RETURNING = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_TIMING0   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMING1   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMING2   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMING3   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PROFILE_A = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PROFILE_B = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SELECT    = 3'd6;

   // 500 us min, 2500 us max, 180 degree limit
   localparam logic [PROFILE_W-1:0] PROFILE_RESET = 32'hB49C_41F4;
   localparam logic [MASK_W-1:0]    SELECT_RESET  = 4'h8;

   typedef struct packed {
      kind_type             kind;
      logic [TIME_W-1:0]    now_time;
      logic [MASK_W-1:0]    trigger_mask;
      logic [CHAN_W-1:0]    servo_index;
      logic [ANGLE_W-1:0]   angle;
   } req_word_type;

   typedef struct packed {
      logic                 write_valid;
      logic [CHAN_W-1:0]    channel;
      logic [PULSE_W-1:0]   pulse_width;
      logic                 accepted;
      logic [MASK_W-1:0]    busy_mask;
      logic [MASK_W-1:0]    returning_mask;
      logic                 last;
   } rsp_word_type;

   typedef struct packed {
      phase_type            phase;
      logic [TIME_W-1:0]    start_time;
   } state_entry_type;

endpackage

// File: hw/rtl/servo_sweep_cycle_sequencer.sv
// ----------------------------------------------------------------------------
// Servo sweep cycle sequencer
// Runs an idle / at-end / returning cycle per servo channel and emits pulse
// width updates for triggers, ticks, set-angle and stop commands.
// ----------------------------------------------------------------------------
// One request word is taken at a time; req_stall stays high until its last
// response word has been loaded into the output register. Per word the block
// sweeps every channel in order: a READ state reads the channel entry of the
// state memory and an EVAL state writes it back; each channel that needs a new
// pulse width also takes 12 steps of the serial restoring divider and a STORE
// state that adds the minimum pulse. The EMIT state then hands out the response
// words one by one, each once the output register is free. The serial divider
// and the single-ported state memory set how long a word takes.
// The phase and phase start time of each channel sit in that memory; a valid
// bit per entry, cleared by reset, makes an unwritten entry read as idle with
// time zero, so no clearing pass is needed. Configuration writes are always
// taken (csr_ready is tied high) and are meant to happen while no request is
// in flight. busy_mask and returning_mask in every response of a request show
// the channel phases after the whole request has been applied.
// ----------------------------------------------------------------------------
module servo_sweep_cycle_sequencer #(
   parameter int SERVO_COUNT = svsq_pkg::SERVO_COUNT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  svsq_pkg::req_word_type              req_data,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output svsq_pkg::rsp_word_type              rsp_data,
   // configuration write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [svsq_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [svsq_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int IDX_W = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;
   localparam logic [svsq_pkg::CHAN_W-1:0] LAST_CHAN = svsq_pkg::CHAN_W'(SERVO_COUNT - 1);
   localparam logic [svsq_pkg::DIV_CNT_W-1:0] DIV_LAST =
      svsq_pkg::DIV_CNT_W'(svsq_pkg::DIV_STEPS - 1);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_READ   = 6'b000010,
      ST_EVAL   = 6'b000100,
      ST_DIVIDE = 6'b001000,
      ST_STORE  = 6'b010000,
      ST_EMIT   = 6'b100000
   } state_type;

   // control
   state_type                              state_ff, state_in;
   logic [svsq_pkg::CHAN_W-1:0]            chan_ff, chan_in;
   logic [SERVO_COUNT-1:0]                 vld_ff, vld_in;
   logic [svsq_pkg::MASK_W-1:0]            busy_ff, busy_in;
   logic [svsq_pkg::MASK_W-1:0]            ret_ff, ret_in;
   logic [SERVO_COUNT-1:0]                 res_incl_ff, res_incl_in;
   logic                                   rsp_valid_ff, rsp_valid_in;
   logic [svsq_pkg::DIV_CNT_W-1:0]         cnt_ff, cnt_in;

   // configuration
   logic [svsq_pkg::TIMING_W-1:0]          timing_ff [svsq_pkg::NUM_TIMING];
   logic [svsq_pkg::TIMING_W-1:0]          timing_in [svsq_pkg::NUM_TIMING];
   logic [svsq_pkg::PROFILE_W-1:0]         prof_a_ff, prof_a_in;
   logic [svsq_pkg::PROFILE_W-1:0]         prof_b_ff, prof_b_in;
   logic [svsq_pkg::MASK_W-1:0]            psel_ff, psel_in;

   // payload
   svsq_pkg::req_word_type                 item_ff, item_in;
   svsq_pkg::rsp_word_type                 rsp_data_ff, rsp_data_in;
   logic [SERVO_COUNT-1:0]                 res_wv_ff, res_wv_in;
   logic [SERVO_COUNT-1:0]                 res_acc_ff, res_acc_in;
   logic [svsq_pkg::PULSE_W-1:0]           res_pw_ff [SERVO_COUNT];
   logic [svsq_pkg::PULSE_W-1:0]           res_pw_in [SERVO_COUNT];
   logic [svsq_pkg::ANGLE_W-1:0]           rem_ff, rem_in;
   logic [svsq_pkg::PULSE_W-1:0]           div_ff, div_in;
   logic [svsq_pkg::ANGLE_W-1:0]           lim_ff, lim_in;
   logic [svsq_pkg::PULSE_W-1:0]           mn_ff, mn_in;

   // state memory
   svsq_pkg::state_entry_type              state_mem [SERVO_COUNT];
   svsq_pkg::state_entry_type              rd_ent_ff;
   logic                                   mem_we;

   // per-channel datapath
   logic [IDX_W-1:0]                       ci;
   svsq_pkg::state_entry_type              cur_ent, new_ent;
   logic [svsq_pkg::TIMING_W-1:0]          tm;
   logic [svsq_pkg::TIME_W-1:0]            elapsed;
   logic                                   incl, wv, acc, need_pulse;
   logic [svsq_pkg::ANGLE_W-1:0]           ang_sel, ang_clamp, lim_raw, lim_eff;
   logic [svsq_pkg::PROFILE_W-1:0]         prof;
   logic [svsq_pkg::PULSE_W-1:0]           p_min, p_max, span;
   logic [svsq_pkg::PRODUCT_W-1:0]         product;
   logic [svsq_pkg::ANGLE_W:0]             trial;
   logic                                   q_bit;

   // response picking
   logic [SERVO_COUNT-1:0]                 low_bit, rest;
   logic [IDX_W-1:0]                       pick_idx;
   logic                                   out_free;

   assign ci        = chan_ff[IDX_W-1:0];
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // An entry never written since reset reads as idle, time zero.
   assign cur_ent = vld_ff[ci] ? rd_ent_ff : '0;
   assign tm      = timing_ff[chan_ff];
   assign elapsed = item_ff.now_time - cur_ent.start_time;

   // Pulse mapping operands: clamp angle to the profile limit, zero span when
   // the profile is inverted.
   assign prof      = psel_ff[chan_ff] ? prof_b_ff : prof_a_ff;
   assign p_min     = prof[11:0];
   assign p_max     = prof[23:12];
   assign lim_raw   = prof[31:24];
   assign lim_eff   = (lim_raw == '0) ? svsq_pkg::ANGLE_W'(1) : lim_raw;
   assign ang_clamp = (ang_sel > lim_eff) ? lim_eff : ang_sel;
   assign span      = (p_max >= p_min) ? (p_max - p_min) : '0;
   assign product   = svsq_pkg::PRODUCT_W'(span) * svsq_pkg::PRODUCT_W'(ang_clamp);

   // One restoring division step: remainder stays below the limit.
   assign trial = {rem_ff, div_ff[svsq_pkg::PULSE_W-1]};
   assign q_bit = (trial >= {1'b0, lim_ff});

   // Lowest pending channel of the response buffer.
   assign low_bit = res_incl_ff & (~res_incl_ff + SERVO_COUNT'(1));
   assign rest    = res_incl_ff & ~low_bit;

   always_comb begin
      pick_idx = '0;
      for (int i = 0; i < SERVO_COUNT; i++) begin
         if (low_bit[i]) begin
            pick_idx = IDX_W'(i);
         end
      end
   end

   // Channel decision for the entry read this sweep step.
   always_comb begin
      incl       = 1'b0;
      wv         = 1'b0;
      acc        = 1'b0;
      need_pulse = 1'b0;
      new_ent    = cur_ent;
      ang_sel    = tm[7:0];
      unique case (item_ff.kind)
         svsq_pkg::KIND_TICK: begin
            ang_sel = tm[7:0];
            if (cur_ent.phase == svsq_pkg::PH_AT_END &&
                elapsed >= svsq_pkg::TIME_W'(tm[31:16])) begin
               incl       = 1'b1;
               wv         = 1'b1;
               need_pulse = 1'b1;
               new_ent.phase      = svsq_pkg::PH_RETURNING;
               new_ent.start_time = item_ff.now_time;
            end else if (cur_ent.phase == svsq_pkg::PH_RETURNING &&
                         elapsed >= svsq_pkg::TIME_W'(tm[47:32])) begin
               new_ent.phase = svsq_pkg::PH_IDLE;
            end
         end
         svsq_pkg::KIND_TRIGGER: begin
            ang_sel = tm[15:8];
            if (item_ff.trigger_mask[chan_ff]) begin
               incl = 1'b1;
               if (cur_ent.phase == svsq_pkg::PH_IDLE) begin
                  wv         = 1'b1;
                  acc        = 1'b1;
                  need_pulse = 1'b1;
                  new_ent.phase      = svsq_pkg::PH_AT_END;
                  new_ent.start_time = item_ff.now_time;
               end
            end
         end
         svsq_pkg::KIND_SET: begin
            ang_sel = item_ff.angle;
            if (item_ff.servo_index == chan_ff) begin
               incl = 1'b1;
               if (cur_ent.phase == svsq_pkg::PH_IDLE) begin
                  wv         = 1'b1;
                  acc        = 1'b1;
                  need_pulse = 1'b1;
               end
            end
         end
         svsq_pkg::KIND_STOP: begin
            ang_sel    = tm[7:0];
            incl       = 1'b1;
            wv         = 1'b1;
            need_pulse = 1'b1;
            new_ent    = '{phase: svsq_pkg::PH_IDLE, start_time: '0};
         end
      endcase
   end

   // Next-state logic for the sequencer, response buffer and output register.
   always_comb begin
      state_in     = state_ff;
      chan_in      = chan_ff;
      vld_in       = vld_ff;
      busy_in      = busy_ff;
      ret_in       = ret_ff;
      res_incl_in  = res_incl_ff;
      rsp_valid_in = rsp_valid_ff;
      cnt_in       = cnt_ff;
      item_in      = item_ff;
      rsp_data_in  = rsp_data_ff;
      res_wv_in    = res_wv_ff;
      res_acc_in   = res_acc_ff;
      res_pw_in    = res_pw_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      lim_in       = lim_ff;
      mn_in        = mn_ff;
      mem_we       = 1'b0;

      // drop the output word once taken; a new load below overrides this
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in     = req_data;
               chan_in     = '0;
               res_incl_in = '0;
               state_in    = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            // write back the entry; nothing else touches it this request
            mem_we           = 1'b1;
            vld_in[ci]       = 1'b1;
            busy_in[chan_ff] = (new_ent.phase != svsq_pkg::PH_IDLE);
            ret_in[chan_ff]  = (new_ent.phase == svsq_pkg::PH_RETURNING);
            res_incl_in[ci]  = incl;
            res_wv_in[ci]    = wv;
            res_acc_in[ci]   = acc;
            res_pw_in[ci]    = '0;
            if (need_pulse) begin
               rem_in   = product[svsq_pkg::PRODUCT_W-1:svsq_pkg::PULSE_W];
               div_in   = product[svsq_pkg::PULSE_W-1:0];
               lim_in   = lim_eff;
               mn_in    = p_min;
               cnt_in   = '0;
               state_in = ST_DIVIDE;
            end else if (chan_ff == LAST_CHAN) begin
               state_in = ST_EMIT;
            end else begin
               chan_in  = chan_ff + 1'b1;
               state_in = ST_READ;
            end
         end
         ST_DIVIDE: begin
            rem_in = q_bit ? svsq_pkg::ANGLE_W'(trial - {1'b0, lim_ff}) : trial[7:0];
            div_in = {div_ff[svsq_pkg::PULSE_W-2:0], q_bit};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            res_pw_in[ci] = svsq_pkg::PULSE_W'(mn_ff + div_ff);
            if (chan_ff == LAST_CHAN) begin
               state_in = ST_EMIT;
            end else begin
               chan_in  = chan_ff + 1'b1;
               state_in = ST_READ;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.busy_mask      = busy_ff;
               rsp_data_in.returning_mask = ret_ff;
               if (res_incl_ff == '0) begin
                  // no channel addressed: one empty word
                  rsp_data_in.write_valid = 1'b0;
                  rsp_data_in.channel     = (item_ff.kind == svsq_pkg::KIND_SET) ?
                                            item_ff.servo_index : '0;
                  rsp_data_in.pulse_width = '0;
                  rsp_data_in.accepted    = 1'b0;
                  rsp_data_in.last        = 1'b1;
                  state_in                = ST_IDLE;
               end else begin
                  rsp_data_in.write_valid = res_wv_ff[pick_idx];
                  rsp_data_in.channel     = svsq_pkg::CHAN_W'(pick_idx);
                  rsp_data_in.pulse_width = res_pw_ff[pick_idx];
                  rsp_data_in.accepted    = res_acc_ff[pick_idx];
                  rsp_data_in.last        = (rest == '0);
                  res_incl_in             = rest;
                  if (rest == '0) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Configuration register writes.
   always_comb begin
      timing_in = timing_ff;
      prof_a_in = prof_a_ff;
      prof_b_in = prof_b_ff;
      psel_in   = psel_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            svsq_pkg::CSR_TIMING0:   timing_in[0] = csr_wdata;
            svsq_pkg::CSR_TIMING1:   timing_in[1] = csr_wdata;
            svsq_pkg::CSR_TIMING2:   timing_in[2] = csr_wdata;
            svsq_pkg::CSR_TIMING3:   timing_in[3] = csr_wdata;
            svsq_pkg::CSR_PROFILE_A: prof_a_in = csr_wdata[svsq_pkg::PROFILE_W-1:0];
            svsq_pkg::CSR_PROFILE_B: prof_b_in = csr_wdata[svsq_pkg::PROFILE_W-1:0];
            svsq_pkg::CSR_SELECT:    psel_in = csr_wdata[svsq_pkg::MASK_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         chan_ff      <= '0;
         vld_ff       <= '0;
         busy_ff      <= '0;
         ret_ff       <= '0;
         res_incl_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         item_ff      <= '0;
         for (int i = 0; i < svsq_pkg::NUM_TIMING; i++) begin
            timing_ff[i] <= '0;
         end
         prof_a_ff    <= svsq_pkg::PROFILE_RESET;
         prof_b_ff    <= svsq_pkg::PROFILE_RESET;
         psel_ff      <= svsq_pkg::SELECT_RESET;
      end else begin
         state_ff     <= state_in;
         chan_ff      <= chan_in;
         vld_ff       <= vld_in;
         busy_ff      <= busy_in;
         ret_ff       <= ret_in;
         res_incl_ff  <= res_incl_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         item_ff      <= item_in;
         timing_ff    <= timing_in;
         prof_a_ff    <= prof_a_in;
         prof_b_ff    <= prof_b_in;
         psel_ff      <= psel_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      res_wv_ff   <= res_wv_in;
      res_acc_ff  <= res_acc_in;
      res_pw_ff   <= res_pw_in;
      rem_ff      <= rem_in;
      div_ff      <= div_in;
      lim_ff      <= lim_in;
      mn_ff       <= mn_in;
   end

   // State memory: read in READ, the cycle before the update; write back in EVAL.
   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) begin
         rd_ent_ff <= state_mem[ci];
      end
      if (mem_we) begin
         state_mem[ci] <= new_ent;
      end
   end

   // A non-final response word means the sequencer is still emitting.
   a_nonlast_in_emit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.last) |-> (state_ff == ST_EMIT))
      else $error("non-final response word while sequencer left emit");

   // Returning channels are always part of the busy set.
   a_returning_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_data_ff.returning_mask & ~rsp_data_ff.busy_mask) == '0))
      else $error("returning channel not marked busy");

   // A word without a pulse update carries no pulse and no acceptance.
   a_empty_word_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.write_valid) |->
      (rsp_data_ff.pulse_width == '0 && !rsp_data_ff.accepted))
      else $error("response without write carries pulse or acceptance");

endmodule

// File: tb/servo_sweep_cycle_sequencer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Servo sweep cycle sequencer testbench
// Drives tick, trigger, set-angle and stop words through the sequencer while
// a behavioral copy of the four channel cycles predicts every response word.
// Each response word is checked field by field against the oldest
// prediction. Random idling on both sides, a long output hold-off and
// several register settings (all-zero and all-one among them) are covered.
// ----------------------------------------------------------------------------
module servo_sweep_cycle_sequencer_tb;
   import svsq_pkg::*;

   localparam int SERVO_COUNT   = SERVO_COUNT_DEF;
   localparam int IDLE_PCT      = 31;
   localparam int HOLD_CYCLES   = 400;
   localparam int DRAIN_LIMIT   = 20000;
   // room for the slowest request word plus the output hand-off
   localparam int SETTLE_CYCLES = 80;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_WORDS   = 45;

   // no register lives at this index; writes to it must be ignored
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;
   // just below the 32-bit wrap, so short cycles straddle it
   localparam logic [TIME_W-1:0]    WRAP_BASE  = 32'hFFFF_FFFC;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_word_type          req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_word_type          rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // predicted copy of the block's registers and per-channel state
   logic [TIMING_W-1:0]   timing_q  [NUM_TIMING];
   logic [PROFILE_W-1:0]  profile_q [2];
   logic [MASK_W-1:0]     select_q;
   phase_type             phase_q   [SERVO_COUNT];
   logic [TIME_W-1:0]     stamp_q   [SERVO_COUNT];

   // pulse updates still owed by the block, oldest first
   rsp_word_type          servo_updates [$];

   int                    errors    = 0;
   int                    gap_pct   = IDLE_PCT;
   int                    stall_pct = IDLE_PCT;
   logic                  hold_active = 1'b0;
   event                  hold_ev;
   logic [TIME_W-1:0]     now_ms;

   servo_sweep_cycle_sequencer #(
      .SERVO_COUNT(SERVO_COUNT)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------

   // Mirror a register write into the predicted settings; unused index drops.
   function automatic void apply_csr(logic [CSR_IDX_W-1:0] idx,
                                     logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_TIMING0, CSR_TIMING1, CSR_TIMING2, CSR_TIMING3:
            timing_q[idx] = data[TIMING_W-1:0];
         CSR_PROFILE_A: profile_q[0] = data[PROFILE_W-1:0];
         CSR_PROFILE_B: profile_q[1] = data[PROFILE_W-1:0];
         CSR_SELECT:    select_q     = data[MASK_W-1:0];
         default: ;
      endcase
   endfunction

   // Map an angle to a compare value through the channel's pulse profile.
   function automatic logic [PULSE_W-1:0] angle_to_pulse(int ch,
                                                         logic [ANGLE_W-1:0] ang);
      logic [PROFILE_W-1:0] prof;
      logic [31:0]          lo, hi, limit, span, clamped;
      prof  = profile_q[select_q[ch]];
      lo    = prof[11:0];
      hi    = prof[23:12];
      limit = prof[31:24];
      // a zero limit behaves as one degree
      if (limit == 0) limit = 1;
      clamped = (ang > limit) ? limit : ang;
      // inverted profile collapses to the minimum pulse
      span = (hi >= lo) ? hi - lo : 0;
      return PULSE_W'(lo + span * clamped / limit);
   endfunction

   function automatic rsp_word_type update_word(logic wv, int ch,
                                                logic [PULSE_W-1:0] pw, logic acc);
      rsp_word_type w;
      w             = '0;
      w.write_valid = wv;
      w.channel     = CHAN_W'(ch);
      w.pulse_width = pw;
      w.accepted    = acc;
      return w;
   endfunction

   // Advance the channel cycles by one request word and queue its responses.
   function automatic void sequence_servos(req_word_type w);
      rsp_word_type      words [$];
      logic [TIME_W-1:0] elapsed;
      logic [MASK_W-1:0] busy, back;
      case (w.kind)
         KIND_TICK: begin
            for (int c = 0; c < SERVO_COUNT; c++) begin
               // wrapping subtraction handles the 32-bit roll-over
               elapsed = w.now_time - stamp_q[c];
               if (phase_q[c] == PH_AT_END && elapsed >= timing_q[c][31:16]) begin
                  words.push_back(update_word(1'b1, c,
                                              angle_to_pulse(c, timing_q[c][7:0]), 1'b0));
                  stamp_q[c] = w.now_time;
                  phase_q[c] = PH_RETURNING;
               end else if (phase_q[c] == PH_RETURNING &&
                            elapsed >= timing_q[c][47:32]) begin
                  phase_q[c] = PH_IDLE;
               end
            end
         end
         KIND_TRIGGER: begin
            for (int c = 0; c < SERVO_COUNT; c++) begin
               if (w.trigger_mask[c]) begin
                  if (phase_q[c] == PH_IDLE) begin
                     words.push_back(update_word(1'b1, c,
                                                 angle_to_pulse(c, timing_q[c][15:8]), 1'b1));
                     stamp_q[c] = w.now_time;
                     phase_q[c] = PH_AT_END;
                  end else begin
                     words.push_back(update_word(1'b0, c, '0, 1'b0));
                  end
               end
            end
         end
         KIND_SET: begin
            if (w.servo_index < SERVO_COUNT && phase_q[w.servo_index] == PH_IDLE)
               words.push_back(update_word(1'b1, w.servo_index,
                                           angle_to_pulse(w.servo_index, w.angle), 1'b1));
            else
               words.push_back(update_word(1'b0, w.servo_index, '0, 1'b0));
         end
         KIND_STOP: begin
            for (int c = 0; c < SERVO_COUNT; c++) begin
               words.push_back(update_word(1'b1, c,
                                           angle_to_pulse(c, timing_q[c][7:0]), 1'b0));
               phase_q[c] = PH_IDLE;
               stamp_q[c] = '0;
            end
         end
      endcase
      // nothing driven: one empty word still closes the request
      if (words.size() == 0) words.push_back(update_word(1'b0, 0, '0, 1'b0));
      busy = '0;
      back = '0;
      for (int c = 0; c < SERVO_COUNT; c++) begin
         busy[c] = (phase_q[c] != PH_IDLE);
         back[c] = (phase_q[c] == PH_RETURNING);
      end
      foreach (words[k]) begin
         words[k].busy_mask      = busy;
         words[k].returning_mask = back;
         words[k].last           = (k == words.size() - 1);
         servo_updates.push_back(words[k]);
      end
   endfunction

   // ------------------------------------------------------------------------
   // Response side: random stall, long hold-off, field-by-field check
   // ------------------------------------------------------------------------

   function automatic void flag_field(string name, logic [31:0] want, logic [31:0] got);
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      errors++;
   endfunction

   function automatic void check_update(rsp_word_type got);
      rsp_word_type want;
      if (servo_updates.size() == 0) begin
         $display("%0t: unexpected response word, expected none, got %h", $time, got);
         errors++;
      end else begin
         want = servo_updates.pop_front();
         if (got.write_valid !== want.write_valid)
            flag_field("write_valid", want.write_valid, got.write_valid);
         if (got.channel !== want.channel)
            flag_field("channel", want.channel, got.channel);
         if (got.pulse_width !== want.pulse_width)
            flag_field("pulse_width", want.pulse_width, got.pulse_width);
         if (got.accepted !== want.accepted)
            flag_field("accepted", want.accepted, got.accepted);
         if (got.busy_mask !== want.busy_mask)
            flag_field("busy_mask", want.busy_mask, got.busy_mask);
         if (got.returning_mask !== want.returning_mask)
            flag_field("returning_mask", want.returning_mask, got.returning_mask);
         if (got.last !== want.last)
            flag_field("last", want.last, got.last);
      end
   endfunction

   // Sample the word taken at this edge, then pick the next stall value.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) check_update(rsp_data);
      rsp_stall <= hold_active || ($urandom_range(99) < stall_pct);
   end

   // Hold the output off for a fixed stretch, counted here in cycles.
   always begin
      @(hold_ev);
      hold_active <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_active <= 1'b0;
   end

   // ------------------------------------------------------------------------
   // Request and register drivers
   // ------------------------------------------------------------------------

   function automatic req_word_type make_word(kind_type kind, logic [TIME_W-1:0] t,
                                              logic [MASK_W-1:0] mask,
                                              logic [CHAN_W-1:0] idx,
                                              logic [ANGLE_W-1:0] ang);
      req_word_type w;
      w.kind         = kind;
      w.now_time     = t;
      w.trigger_mask = mask;
      w.servo_index  = idx;
      w.angle        = ang;
      return w;
   endfunction

   // Offer one request word after a random gap; predict once it is taken.
   task automatic send_word(req_word_type w);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sequence_servos(w);
   endtask

   // Drop valid, wait until every owed word has come, then let the block settle.
   task automatic wait_quiet();
      int waited;
      req_valid <= 1'b0;
      waited = 0;
      do begin
         @(posedge clock);
         waited++;
      end while (servo_updates.size() != 0 && waited < DRAIN_LIMIT);
      if (servo_updates.size() != 0) begin
         $display("%0t: %0d response words missing, expected %h, got none",
                  $time, servo_updates.size(), servo_updates[0]);
         errors++;
         servo_updates.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Present one register write; valid stays up for a following write.
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_csr(idx, data);
   endtask

   task automatic load_settings(input logic [TIMING_W-1:0] timing [NUM_TIMING],
                                input logic [CSR_DATA_W-1:0] prof_a,
                                input logic [CSR_DATA_W-1:0] prof_b,
                                input logic [CSR_DATA_W-1:0] sel);
      for (int i = 0; i < NUM_TIMING; i++)
         write_csr(CSR_TIMING0 + CSR_IDX_W'(i), timing[i]);
      write_csr(CSR_PROFILE_A, prof_a);
      write_csr(CSR_PROFILE_B, prof_b);
      write_csr(CSR_SELECT, sel);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [TIMING_W-1:0] pack_timing(logic [ANGLE_W-1:0] start_ang,
                                                       logic [ANGLE_W-1:0] end_ang,
                                                       logic [MS_W-1:0] out_ms,
                                                       logic [MS_W-1:0] ret_ms);
      return {ret_ms, out_ms, end_ang, start_ang};
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pack_profile(logic [PULSE_W-1:0] lo,
                                                          logic [PULSE_W-1:0] hi,
                                                          logic [ANGLE_W-1:0] lim);
      return {16'h0, lim, hi, lo};
   endfunction

   // Mostly short times so cycles complete; now and then a full 16-bit time.
   function automatic logic [TIMING_W-1:0] random_timing();
      logic [MS_W-1:0] out_ms, ret_ms;
      out_ms = ($urandom_range(7) == 0) ? MS_W'($urandom) : MS_W'($urandom_range(12));
      ret_ms = ($urandom_range(7) == 0) ? MS_W'($urandom) : MS_W'($urandom_range(12));
      return pack_timing(ANGLE_W'($urandom), ANGLE_W'($urandom), out_ms, ret_ms);
   endfunction

   // Plausible servo profile most of the time, raw bits otherwise; junk on top.
   function automatic logic [CSR_DATA_W-1:0] random_profile();
      logic [PULSE_W-1:0] lo, hi;
      logic [ANGLE_W-1:0] lim;
      if ($urandom_range(3) == 0) return {16'($urandom), 32'($urandom)};
      lo  = PULSE_W'($urandom_range(300, 900));
      hi  = PULSE_W'($urandom_range(1500, 2800));
      lim = ANGLE_W'($urandom_range(90, 255));
      return {16'($urandom), lim, hi, lo};
   endfunction

   // Mix of advancing ticks, triggers, set-angle and stop, plus some noise.
   task automatic send_sweep_traffic(int count);
      int pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            // mostly small steps; rare large jumps push long times through
            now_ms += ($urandom_range(19) == 0) ? $urandom : $urandom_range(6);
            send_word(make_word(KIND_TICK, now_ms, MASK_W'($urandom),
                                CHAN_W'($urandom), ANGLE_W'($urandom)));
         end else if (pick < 68) begin
            send_word(make_word(KIND_TRIGGER, now_ms, MASK_W'($urandom_range(1, 15)),
                                CHAN_W'($urandom), ANGLE_W'($urandom)));
         end else if (pick < 80) begin
            send_word(make_word(KIND_SET, now_ms, MASK_W'($urandom),
                                CHAN_W'($urandom), ANGLE_W'($urandom)));
         end else if (pick < 85) begin
            send_word(make_word(KIND_STOP, now_ms, MASK_W'($urandom),
                                CHAN_W'($urandom), ANGLE_W'($urandom)));
         end else begin
            send_word(make_word(kind_type'($urandom_range(3)), $urandom,
                                MASK_W'($urandom), CHAN_W'($urandom),
                                ANGLE_W'($urandom)));
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   task automatic test_directed_corners();
      logic [TIMING_W-1:0] timing [NUM_TIMING];
      // reset settings: zero timings, 500..2500 us over 180 degrees
      send_word(make_word(KIND_SET, '0, '0, 2'd0, 8'd0));
      send_word(make_word(KIND_SET, '0, '0, 2'd3, 8'd255));     // clamp to limit
      send_word(make_word(KIND_TICK, '0, '0, '0, '0));          // nothing moves
      send_word(make_word(KIND_TRIGGER, '1, 4'h0, '0, '0));     // empty mask
      wait_quiet();

      timing[0] = pack_timing(8'd0, 8'd180, 16'd5, 16'd3);
      timing[1] = pack_timing(8'd255, 8'd90, 16'd0, 16'd0);     // zero times
      timing[2] = pack_timing(8'd10, 8'd200, 16'hFFFF, 16'hFFFF);
      timing[3] = pack_timing(8'd45, 8'd135, 16'd2, 16'd1);
      write_csr(CSR_UNUSED, '1);
      // profile a has a zero angle limit, profile b an inverted span
      load_settings(timing, pack_profile(12'd100, 12'd4095, 8'd0),
                    pack_profile(12'd3000, 12'd1000, 8'd255), 48'h5);

      send_word(make_word(KIND_TRIGGER, WRAP_BASE, 4'hF, '0, '0));
      send_word(make_word(KIND_TRIGGER, WRAP_BASE, 4'h3, '0, '0));   // busy, refused
      send_word(make_word(KIND_SET, WRAP_BASE, '0, 2'd0, 8'd100));   // busy, refused
      send_word(make_word(KIND_TICK, WRAP_BASE, '0, '0, '0));
      send_word(make_word(KIND_TICK, WRAP_BASE + 2, '0, '0, '0));
      send_word(make_word(KIND_TICK, WRAP_BASE + 5, '0, '0, '0));    // across the wrap
      send_word(make_word(KIND_TICK, WRAP_BASE + 8, '0, '0, '0));
      send_word(make_word(KIND_SET, WRAP_BASE + 8, '0, 2'd1, 8'd0));
      send_word(make_word(KIND_SET, WRAP_BASE + 8, '0, 2'd1, 8'd255));
      send_word(make_word(KIND_STOP, WRAP_BASE + 8, '0, '0, '0));    // one still at end
      send_word(make_word(KIND_TICK, '1, '0, '0, '0));
      send_word(make_word(KIND_STOP, '0, '0, '0, '0));

      // full 16-bit outbound and return times on channel 2
      send_word(make_word(KIND_TRIGGER, '0, 4'h4, '0, '0));
      send_word(make_word(KIND_TICK, 32'h0000_FFFE, '0, '0, '0));
      send_word(make_word(KIND_TICK, 32'h0000_FFFF, '0, '0, '0));
      send_word(make_word(KIND_TICK, 32'h0001_FFFD, '0, '0, '0));
      send_word(make_word(KIND_TICK, 32'h0001_FFFE, '0, '0, '0));
      wait_quiet();
   endtask

   // One settings block per phase: all zeros, all ones, then random ones.
   task automatic test_random_sweeps();
      logic [TIMING_W-1:0] timing [NUM_TIMING];
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         foreach (timing[i])
            timing[i] = (p == 0) ? {TIMING_W{1'b0}} :
                        (p == 1) ? {TIMING_W{1'b1}} : random_timing();
         if (p == 0)
            load_settings(timing, '0, '0, '0);
         else if (p == 1)
            load_settings(timing, '1, '1, '1);
         else
            load_settings(timing, random_profile(), random_profile(),
                          CSR_DATA_W'({$urandom, $urandom}));
         now_ms = (p == 3) ? 32'hFFFF_FFF0 : $urandom;
         send_sweep_traffic(PHASE_WORDS);
         wait_quiet();
      end
   endtask

   // Back-to-back words with no idling on either side.
   task automatic test_full_rate();
      gap_pct   = 0;
      stall_pct = 0;
      now_ms    = $urandom;
      send_sweep_traffic(40);
      wait_quiet();
      gap_pct   = IDLE_PCT;
      stall_pct = IDLE_PCT;
   endtask

   // Hold the output while triggers and ticks keep coming, so the block backs up.
   task automatic test_output_backpressure();
      gap_pct = 0;
      -> hold_ev;
      for (int n = 0; n < 16; n++) begin
         send_word(make_word((n % 2) ? KIND_TICK : KIND_TRIGGER, now_ms, 4'hF,
                             CHAN_W'($urandom), ANGLE_W'($urandom)));
         now_ms += 3;
      end
      gap_pct = IDLE_PCT;
      wait_quiet();
   endtask

   // Pause the sender until every owed word is in, then carry on unchanged.
   task automatic test_drain_and_resume();
      send_sweep_traffic(12);
      wait_quiet();
      send_sweep_traffic(12);
      wait_quiet();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      // registers come up at their reset values
      foreach (timing_q[i]) timing_q[i] = '0;
      profile_q[0] = PROFILE_RESET;
      profile_q[1] = PROFILE_RESET;
      select_q     = SELECT_RESET;
      foreach (phase_q[i]) begin
         phase_q[i] = PH_IDLE;
         stamp_q[i] = '0;
      end

      test_directed_corners();
      test_random_sweeps();
      test_full_rate();
      test_output_backpressure();
      test_drain_and_resume();

      if (errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // Bound the run well beyond the slowest legal pass.
   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
